// ===== rtl/bltape_pkg.sv =====
// Package: constants, types and codes shared by the tape machine modules.
package bltape_pkg;

  localparam int TapeDepth    = 32768;
  localparam int ProgramDepth = 4096;
  localparam int StackDepth   = 256;

  localparam int TapeAw  = $clog2(TapeDepth);
  localparam int ProgAw  = $clog2(ProgramDepth);
  localparam int StackAw = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int LenW    = $clog2(ProgramDepth + 1);
  localparam int LevelW  = $clog2(StackDepth + 1);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_STEP   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CLOSE = 2'd1;
  localparam logic [1:0] ST_OPEN  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {PH_LOADING, PH_RUNNING, PH_ERROR} phase_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_EXEC, S_LOADPOP, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;   // write zero at clear address, advance
    logic capture;      // latch input beat
    logic fetch;        // issue program/jump/tape reads
    logic execute;      // perform step instruction
    logic load_start;   // handle load/finish; read stack for ']'
    logic load_finish;  // complete ']' load after stack read
    logic out_load;     // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic is_step;      // captured beat is a runnable step
    logic need_pop;     // captured load is a legal ']'
  } sts_t;

endpackage

// ===== rtl/bltape_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module bltape_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/bltape_ctrl.sv =====
// Controller state machine for the tape machine.
module bltape_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid_q,
  input  logic                out_ready,
  input  bltape_pkg::sts_t    sts,
  output bltape_pkg::cmd_t    cmd
);
  bltape_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bltape_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bltape_pkg::S_CLEAR:   if (sts.clear_done) state_nxt = bltape_pkg::S_IDLE;
      bltape_pkg::S_IDLE: begin
        if (in_valid) state_nxt = bltape_pkg::S_FETCH;
      end
      bltape_pkg::S_FETCH: begin
        if (sts.is_step) state_nxt = bltape_pkg::S_EXEC;
        else if (sts.need_pop) state_nxt = bltape_pkg::S_LOADPOP;
        else state_nxt = bltape_pkg::S_OUT;
      end
      bltape_pkg::S_EXEC:    state_nxt = bltape_pkg::S_OUT;
      bltape_pkg::S_LOADPOP: state_nxt = bltape_pkg::S_OUT;
      bltape_pkg::S_OUT: begin
        if (out_ready) state_nxt = bltape_pkg::S_IDLE;
      end
      default: state_nxt = bltape_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid_q = 1'b0;
    unique case (state_r)
      bltape_pkg::S_CLEAR: cmd.clear_step = 1'b1;
      bltape_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = 1'b1;
      end
      bltape_pkg::S_FETCH: begin
        cmd.fetch = 1'b1;
        cmd.load_start = ~sts.is_step;
        cmd.out_load = ~sts.is_step & ~sts.need_pop;
      end
      bltape_pkg::S_EXEC: begin
        cmd.execute = 1'b1;
        cmd.out_load = 1'b1;
      end
      bltape_pkg::S_LOADPOP: begin
        cmd.load_finish = 1'b1;
        cmd.out_load = 1'b1;
      end
      bltape_pkg::S_OUT: out_valid_q = 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== rtl/bltape_dp.sv =====
// Datapath: program, jump, stack and tape stores plus machine registers.
module bltape_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  bltape_pkg::cmd_t cmd,
  output bltape_pkg::sts_t sts,
  input  logic [1:0]       in_operation,
  input  logic [7:0]       in_program_byte,
  input  logic [7:0]       in_in_byte,
  input  logic             in_in_eof,
  output logic             out_out_valid,
  output logic [7:0]       out_out_byte,
  output logic             out_input_used,
  output logic             out_halted,
  output logic [1:0]       out_status
);
  localparam int TAw = bltape_pkg::TapeAw;
  localparam int PAw = bltape_pkg::ProgAw;
  localparam int SAw = bltape_pkg::StackAw;
  localparam int LW  = bltape_pkg::LenW;
  localparam int VW  = bltape_pkg::LevelW;

  // captured beat
  logic [1:0] op_r;
  logic [7:0] pb_r, ib_r;
  logic       eof_r;

  bltape_pkg::phase_t phase_r;
  logic [1:0]  err_r;
  logic [VW-1:0] level_r;
  logic [LW-1:0] len_r, ip_r;
  logic [TAw-1:0] cp_r, clr_r;
  logic        clr_done_r;

  // result register
  logic       ov_r, used_r;
  logic [7:0] ob_r;

  // memory ports
  logic          prog_we, jmp_we, stk_we, tape_we;
  logic [PAw-1:0] jmp_waddr, jmp_wdata;
  logic [7:0]     prog_rdata, tape_rdata, tape_wdata;
  logic [PAw-1:0] jmp_rdata, stk_rdata;
  logic [TAw-1:0] tape_waddr;
  logic [SAw-1:0] stk_waddr, stk_raddr;
  logic [PAw-1:0] pos;

  assign pos = len_r[PAw-1:0];

  bltape_ram #(.Width(8), .Depth(bltape_pkg::ProgramDepth)) u_prog (
    .clk, .we(prog_we), .waddr(pos), .wdata(pb_r),
    .raddr(ip_r[PAw-1:0]), .rdata(prog_rdata));

  bltape_ram #(.Width(PAw), .Depth(bltape_pkg::ProgramDepth)) u_jmp (
    .clk, .we(jmp_we), .waddr(jmp_waddr), .wdata(jmp_wdata),
    .raddr(ip_r[PAw-1:0]), .rdata(jmp_rdata));

  bltape_ram #(.Width(PAw), .Depth(bltape_pkg::StackDepth)) u_stk (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(pos),
    .raddr(stk_raddr), .rdata(stk_rdata));

  bltape_ram #(.Width(8), .Depth(bltape_pkg::TapeDepth)) u_tape (
    .clk, .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
    .raddr(cp_r), .rdata(tape_rdata));

  // load decode
  logic is_open, is_close, full, stk_full, legal_close;
  assign is_open  = (pb_r == bltape_pkg::CH_OPEN);
  assign is_close = (pb_r == bltape_pkg::CH_CLOSE);
  assign full     = (len_r >= LW'(bltape_pkg::ProgramDepth));
  assign stk_full = (level_r >= VW'(bltape_pkg::StackDepth));
  assign legal_close = (phase_r == bltape_pkg::PH_LOADING) &&
                       (op_r == bltape_pkg::OP_LOAD) && !full && is_close &&
                       (level_r != '0);
  assign stk_waddr = level_r[SAw-1:0];
  assign stk_raddr = SAw'(level_r - VW'(1));

  assign sts.clear_done = clr_done_r;
  assign sts.is_step = (phase_r == bltape_pkg::PH_RUNNING) &&
                       (op_r == bltape_pkg::OP_STEP) && (ip_r < len_r);
  assign sts.need_pop = legal_close;

  // step decode
  logic [7:0]    cell_plus, cell_minus;
  logic          cell_zero, lf;
  logic [LW-1:0] jump_next;
  logic [LW-1:0] ip_step;
  assign cell_plus  = tape_rdata + 8'd1;
  assign cell_minus = tape_rdata - 8'd1;
  assign cell_zero  = (tape_rdata == 8'd0);
  assign lf = (ib_r == bltape_pkg::CH_LF) || (ib_r == bltape_pkg::CH_CR);
  assign jump_next = LW'(jmp_rdata) + LW'(1);

  function automatic logic in_eof_or_byte();
    return eof_r || !lf;
  endfunction

  // open -> pos written in the cycle after pos -> open
  logic          pend_r;
  logic [PAw-1:0] pend_addr_r, pend_data_r;

  always_comb begin
    prog_we = 1'b0; jmp_we = 1'b0; stk_we = 1'b0; tape_we = 1'b0;
    jmp_waddr = pos; jmp_wdata = stk_rdata;
    tape_waddr = cp_r; tape_wdata = 8'd0;
    if (cmd.clear_step) begin
      tape_we = 1'b1;
      tape_waddr = clr_r;
    end
    if (cmd.load_start && phase_r == bltape_pkg::PH_LOADING &&
        op_r == bltape_pkg::OP_LOAD && !full && !is_close &&
        !(is_open && stk_full)) begin
      prog_we = 1'b1;
      stk_we = is_open;
    end
    if (cmd.load_finish) begin
      prog_we = 1'b1;
      jmp_we = 1'b1;   // pos -> open
    end
    if (pend_r) begin
      jmp_we = 1'b1;   // open -> pos
      jmp_waddr = pend_addr_r;
      jmp_wdata = pend_data_r;
    end
    if (cmd.execute) begin
      unique case (prog_rdata)
        bltape_pkg::CH_PLUS:  begin tape_we = 1'b1; tape_wdata = cell_plus; end
        bltape_pkg::CH_MINUS: begin tape_we = 1'b1; tape_wdata = cell_minus; end
        bltape_pkg::CH_COMMA: begin
          tape_we = in_eof_or_byte();
          tape_wdata = eof_r ? 8'd0 : ib_r;
        end
        default: ;
      endcase
    end
  end

  // next instruction pointer of a step
  always_comb begin
    ip_step = ip_r + LW'(1);
    if (cmd.execute) begin
      unique case (prog_rdata)
        bltape_pkg::CH_COMMA: if (!eof_r && lf) ip_step = ip_r;
        bltape_pkg::CH_OPEN:  if (cell_zero) ip_step = jump_next;
        bltape_pkg::CH_CLOSE: if (!cell_zero) ip_step = jump_next;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_operation; pb_r <= in_program_byte;
      ib_r <= in_in_byte; eof_r <= in_in_eof;
    end
    if (cmd.load_finish) begin
      pend_addr_r <= stk_rdata;
      pend_data_r <= pos;
    end
    if (cmd.out_load) begin
      ov_r <= cmd.execute && prog_rdata == bltape_pkg::CH_DOT;
      ob_r <= (cmd.execute && prog_rdata == bltape_pkg::CH_DOT) ? tape_rdata : 8'd0;
      used_r <= cmd.execute && prog_rdata == bltape_pkg::CH_COMMA;
    end
  end

  // machine state registers; the open -> pos jump entry is written in the cycle after load_finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bltape_pkg::PH_LOADING;
      err_r <= bltape_pkg::ST_OK;
      level_r <= '0; len_r <= '0; ip_r <= '0; cp_r <= '0;
      clr_r <= '0; clr_done_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.load_finish;
      if (cmd.clear_step) begin
        clr_r <= clr_r + TAw'(1);
        if (clr_r == TAw'(bltape_pkg::TapeDepth - 1)) clr_done_r <= 1'b1;
      end
      if (cmd.load_start && phase_r == bltape_pkg::PH_LOADING) begin
        if (op_r == bltape_pkg::OP_LOAD) begin
          if (full || (is_open && stk_full)) begin
            phase_r <= bltape_pkg::PH_ERROR; err_r <= bltape_pkg::ST_FULL;
          end else if (is_close && level_r == '0) begin
            phase_r <= bltape_pkg::PH_ERROR; err_r <= bltape_pkg::ST_CLOSE;
          end else if (is_close) begin
            level_r <= level_r - VW'(1);
          end else begin
            if (is_open) level_r <= level_r + VW'(1);
            len_r <= len_r + LW'(1);
          end
        end else if (op_r == bltape_pkg::OP_FINISH) begin
          if (level_r != '0) begin
            phase_r <= bltape_pkg::PH_ERROR; err_r <= bltape_pkg::ST_OPEN;
          end else begin
            phase_r <= bltape_pkg::PH_RUNNING; ip_r <= '0;
          end
        end
      end
      if (cmd.load_finish) len_r <= len_r + LW'(1);
      if (cmd.execute) begin
        ip_r <= ip_step;
        unique case (prog_rdata)
          bltape_pkg::CH_RIGHT:
            cp_r <= (cp_r == TAw'(bltape_pkg::TapeDepth - 1)) ? '0 : cp_r + TAw'(1);
          bltape_pkg::CH_LEFT:
            cp_r <= (cp_r == '0) ? TAw'(bltape_pkg::TapeDepth - 1) : cp_r - TAw'(1);
          default: ;
        endcase
      end
    end
  end

  assign out_out_valid  = ov_r;
  assign out_out_byte   = ob_r;
  assign out_input_used = used_r;
  assign out_halted     = (phase_r == bltape_pkg::PH_RUNNING) && (ip_r >= len_r);
  assign out_status     = err_r;

`ifndef SYNTHESIS
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= VW'(bltape_pkg::StackDepth)) else $error("stack level overflow");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(bltape_pkg::ProgramDepth)) else $error("program length overflow");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == bltape_pkg::PH_ERROR) |=> (phase_r == bltape_pkg::PH_ERROR))
    else $error("left error phase");
`endif
endmodule

// ===== rtl/bracket_loop_tape_interpreter_unit.sv =====
// Top level of the bracket-loop tape interpreter.
// Loads a program byte per beat, pairs brackets at load time, then executes
// one instruction per step beat; one result beat per input beat. After reset
// a clearing pass zeroes the tape, one cell a cycle, with in_ready low until
// it ends. A beat is taken in the idle state (S_IDLE); a runnable step or a
// legal ']' load then passes through S_FETCH for the registered memory reads
// and S_EXEC or S_LOADPOP to execute or finish the bracket pairing, any other
// beat only S_FETCH, before the result is offered in S_OUT. A new beat is
// taken only after out_ready has accepted that result, so beats do not
// overlap.
module bracket_loop_tape_interpreter_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_program_byte,
  input  logic [7:0] in_in_byte,
  input  logic       in_in_eof,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_out_valid,
  output logic [7:0] out_out_byte,
  output logic       out_input_used,
  output logic       out_halted,
  output logic [1:0] out_status
);
  bltape_pkg::cmd_t cmd;
  bltape_pkg::sts_t sts;

  bltape_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid_q(out_valid),
    .out_ready, .sts, .cmd);

  bltape_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_operation, .in_program_byte,
    .in_in_byte, .in_in_eof, .out_out_valid, .out_out_byte,
    .out_input_used, .out_halted, .out_status);

`ifndef SYNTHESIS
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and result overlap");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result beat dropped");
  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("double accept");
`endif
endmodule
